[hw/rtl/qstm_pkg.sv]
package qstm_pkg;

  // Fixed field formats of the stream payloads.
  localparam int QUAT_W          = 16;
  localparam int SCALE_W         = 16;
  localparam int TRANS_W         = 32;
  localparam int MAT_W           = 24;
  localparam int SCALE_FRAC_BITS = 8;
  localparam int OUT_FRAC_BITS   = 14;

  // Default fraction width of the quaternion components (Q2.14).
  localparam int QUAT_FRAC_BITS_DEF = 14;

  localparam int N_ENTRIES = 9;

  // Packed stream widths, padded to whole bytes.
  localparam int IN_BITS   = 4 * QUAT_W + SCALE_W + 3 * TRANS_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = N_ENTRIES * MAT_W + 3 * TRANS_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Items the pipeline can hold at once.
  localparam int PIPE_DEPTH = 4;

endpackage

[hw/rtl/quaternion_scale_translate_matrix.sv]
// Channel  | Direction | Payload (tdata, lowest bits first)
// ---------+-----------+-------------------------------------------------------------
// in_      | slave     | quat_w, quat_x, quat_y, quat_z, scale, translation_x/y/z
// out_     | master    | m00 m10 m20 m01 m11 m21 m02 m12 m22, out_tx, out_ty, out_tz
//
// One item can enter in every cycle unless an output stall has filled all stages. Four
// register stages (products, matrix entries, scale multiply, round and saturate) load in
// order, the first at the input transfer; out_tvalid is the valid bit of the last stage.
// Reset (rst_n low, synchronous) clears only the stage valid bits; data is left as is.
// A stall on out_tready holds the last stage and backs up stage by stage; empty stages
// keep accepting, so in_tready drops only when all four stages hold an item.
module quaternion_scale_translate_matrix #(
  parameter int QUAT_FRAC_BITS = qstm_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48], scale[79:64],
  // translation_x[111:80], translation_y[143:112], translation_z[175:144]
  input  logic [qstm_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // m00[23:0], m10[47:24], m20[71:48], m01[95:72], m11[119:96], m21[143:120],
  // m02[167:144], m12[191:168], m22[215:192], out_tx[247:216], out_ty[279:248],
  // out_tz[311:280]
  output logic [qstm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import qstm_pkg::*;

  // Width of a matrix entry before scaling: the constant one has 2*QUAT_FRAC_BITS
  // fraction bits, and twice a sum of two 32-bit products needs 34 bits plus sign.
  localparam int EW_ONE = 2 * QUAT_FRAC_BITS + 3;
  localparam int EW     = (EW_ONE > 36) ? EW_ONE : 36;
  // Entry times the unsigned scale, with a sign bit for the scale operand.
  localparam int PW     = EW + SCALE_W + 1;
  // Shift from 2*QUAT_FRAC_BITS+8 fraction bits down to the output format.
  localparam int RSHIFT = 2 * QUAT_FRAC_BITS + SCALE_FRAC_BITS - OUT_FRAC_BITS;
  localparam int PROD_W = 2 * QUAT_W;

  localparam logic signed [EW-1:0] ONE_E    = EW'(1) << (2 * QUAT_FRAC_BITS);
  localparam logic signed [PW-1:0] HALF_P   = PW'(1) << (RSHIFT - 1);
  localparam logic signed [PW-1:0] SAT_MAX  = PW'((1 << (MAT_W - 1)) - 1);
  localparam logic signed [PW-1:0] SAT_MIN  = -PW'(1 << (MAT_W - 1));

  // Unpack the input payload.
  logic signed [QUAT_W-1:0]  qw, qx, qy, qz;
  logic        [SCALE_W-1:0] in_scale;
  logic        [3*TRANS_W-1:0] in_trans;

  assign qw       = in_tdata[QUAT_W-1:0];
  assign qx       = in_tdata[2*QUAT_W-1:QUAT_W];
  assign qy       = in_tdata[3*QUAT_W-1:2*QUAT_W];
  assign qz       = in_tdata[4*QUAT_W-1:3*QUAT_W];
  assign in_scale = in_tdata[4*QUAT_W+SCALE_W-1:4*QUAT_W];
  assign in_trans = in_tdata[IN_BITS-1:4*QUAT_W+SCALE_W];

  // Stage handshake: a stage takes a new item when it is empty or its item moves on.
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Stage 1: the nine quaternion component products.
  logic signed [PROD_W-1:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic [SCALE_W-1:0]   scale1_r;
  logic [3*TRANS_W-1:0] trans1_r;

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      xx_r     <= PROD_W'(qx * qx);
      yy_r     <= PROD_W'(qy * qy);
      zz_r     <= PROD_W'(qz * qz);
      xy_r     <= PROD_W'(qx * qy);
      xz_r     <= PROD_W'(qx * qz);
      yz_r     <= PROD_W'(qy * qz);
      wx_r     <= PROD_W'(qw * qx);
      wy_r     <= PROD_W'(qw * qy);
      wz_r     <= PROD_W'(qw * qz);
      scale1_r <= in_scale;
      trans1_r <= in_trans;
    end
  end

  // Stage 2: rotation matrix entries, column-major order (m00 m10 m20 m01 ...).
  logic signed [EW-1:0] e_nxt [N_ENTRIES];
  logic signed [EW-1:0] e_r   [N_ENTRIES];
  logic [SCALE_W-1:0]   scale2_r;
  logic [3*TRANS_W-1:0] trans2_r;

  always_comb begin
    e_nxt[0] = ONE_E - ((EW'(yy_r) + EW'(zz_r)) <<< 1);
    e_nxt[1] = (EW'(xy_r) + EW'(wz_r)) <<< 1;
    e_nxt[2] = (EW'(xz_r) - EW'(wy_r)) <<< 1;
    e_nxt[3] = (EW'(xy_r) - EW'(wz_r)) <<< 1;
    e_nxt[4] = ONE_E - ((EW'(xx_r) + EW'(zz_r)) <<< 1);
    e_nxt[5] = (EW'(yz_r) + EW'(wx_r)) <<< 1;
    e_nxt[6] = (EW'(xz_r) + EW'(wy_r)) <<< 1;
    e_nxt[7] = (EW'(yz_r) - EW'(wx_r)) <<< 1;
    e_nxt[8] = ONE_E - ((EW'(xx_r) + EW'(yy_r)) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      e_r      <= e_nxt;
      scale2_r <= scale1_r;
      trans2_r <= trans1_r;
    end
  end

  // Stage 3: each entry times the scale, exact.
  logic signed [PW-1:0] p_nxt [N_ENTRIES];
  logic signed [PW-1:0] p_r   [N_ENTRIES];
  logic signed [SCALE_W:0] scale_s;
  logic [3*TRANS_W-1:0] trans3_r;

  assign scale_s = $signed({1'b0, scale2_r});

  always_comb begin
    for (int i = 0; i < N_ENTRIES; i++) begin
      p_nxt[i] = PW'(e_r[i]) * PW'(scale_s);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      p_r      <= p_nxt;
      trans3_r <= trans2_r;
    end
  end

  // Stage 4: round to nearest with ties away from zero, then saturate. Subtracting
  // one before the arithmetic shift turns a negative tie toward minus infinity.
  logic signed [PW-1:0]    rnd  [N_ENTRIES];
  logic signed [PW-1:0]    q    [N_ENTRIES];
  logic        [MAT_W-1:0] m_nxt [N_ENTRIES];
  logic        [MAT_W-1:0] m_r   [N_ENTRIES];
  logic [3*TRANS_W-1:0]    trans4_r;

  always_comb begin
    for (int i = 0; i < N_ENTRIES; i++) begin
      rnd[i] = p_r[i] + HALF_P - PW'(p_r[i][PW-1]);
      q[i]   = rnd[i] >>> RSHIFT;
      if (q[i] > SAT_MAX) begin
        m_nxt[i] = SAT_MAX[MAT_W-1:0];
      end else if (q[i] < SAT_MIN) begin
        m_nxt[i] = SAT_MIN[MAT_W-1:0];
      end else begin
        m_nxt[i] = q[i][MAT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      m_r      <= m_nxt;
      trans4_r <= trans3_r;
    end
  end

  // Pack the result payload.
  always_comb begin
    out_tdata = '0;
    for (int i = 0; i < N_ENTRIES; i++) begin
      out_tdata[i*MAT_W +: MAT_W] = m_r[i];
    end
    out_tdata[N_ENTRIES*MAT_W +: 3*TRANS_W] = trans4_r;
  end

  assign out_tvalid = v4_r;

endmodule

[hw/rtl/qstm_checker.sv]
module qstm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [qstm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import qstm_pkg::*;

  // Items accepted but not yet delivered.
  logic [2:0] occ_r;
  logic [2:0] occ_nxt;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  always_comb begin
    occ_nxt = occ_r;
    if (in_xfer && !out_xfer) occ_nxt = occ_r + 3'd1;
    else if (!in_xfer && out_xfer) occ_nxt = occ_r - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or vanished");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= 3'(PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> occ_r != 3'd0)
    else $error("result offered with no item in flight");

  a_full_rate: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while the output is free");

endmodule

bind quaternion_scale_translate_matrix qstm_checker u_qstm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
